@@ rtl/vcm_pkg.sv @@
// shared types and codes for the volume curve map and inverse unit
// used by vcm_mul, vcm_div and volume_curve_map_and_inverse_unit
package vcm_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_FLOOR   = 2'd0;
  localparam logic [1:0] REG_CEILING = 2'd1;
  localparam logic [1:0] REG_FULL    = 2'd2;

  // opcodes
  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // reset values of the registers
  localparam logic [7:0] FLOOR_RESET   = 8'd128;
  localparam logic [7:0] CEILING_RESET = 8'd255;
  localparam logic [7:0] FULL_RESET    = 8'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEN,
    ST_PROBE,
    ST_GAP,
    ST_SPAN,
    ST_DIV,
    ST_FINISH
  } state_t;

  // start request to a bit-serial unit
  typedef struct packed {
    logic        start;
    logic [15:0] a;
    logic [7:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [15:0] den;
  } div_req_t;

endpackage

@@ rtl/volume_curve_map_and_inverse_unit.sv @@
// top level of the volume curve map and inverse unit
// depends on vcm_pkg, vcm_mul and vcm_div
//
// Usage:
//   Request channel (req_valid / req_stall) carries opcode and value_in;
//   response channel (rsp_valid / rsp_stall) carries value_out, one item
//   per request. Opcode OP_FORWARD maps a slider setting to a drive level
//   along the inverted-square curve, OP_INVERSE binary-searches the slider
//   setting whose level matches value_in.
//   Registers level_floor, level_ceiling and slider_full_scale are written
//   through cfg_we / cfg_index / cfg_data while the unit is idle; the user
//   is bound to that, the unit itself does not enforce it. One item is
//   worked on at a time; req_stall is high from acceptance until the result
//   is loaded into the output register. A forward item runs f*f, the
//   squared gap, the span product and the quotient, each bit-serial plus a
//   handoff; an inverse item runs f*f once and the other three per probe,
//   at most 9 probes; full scale zero needs no arithmetic. The next item
//   can be accepted in the cycle after its result loads.
//   A stalled result holds in the output register; the next item can be
//   accepted meanwhile, and its result waits until the first is taken.
//   Reset (rst, synchronous) empties the output register, returns to idle
//   and loads the registers with 128, 255 and 100.
module volume_curve_map_and_inverse_unit import vcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       opcode,
  input  logic [7:0] value_in,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] value_out,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] level_floor;
  logic [7:0] level_ceiling;
  logic [7:0] slider_full_scale;

  state_t      state, state_next;
  logic        mode, mode_next;
  logic [7:0]  target, target_next;
  logic [7:0]  vol, vol_next;
  logic [8:0]  bot, bot_next;
  logic [8:0]  top1, top1_next;
  logic [15:0] den, den_next;
  logic [7:0]  result, result_next;
  logic        load_out;

  mul_req_t    mreq;
  div_req_t    dreq;
  logic        mul_done;
  logic [23:0] mul_prod;
  logic        div_done;
  logic [7:0]  div_quo;

  logic        neg;
  logic [7:0]  mag;
  logic [9:0]  mid_sum;
  logic [7:0]  mid;
  logic [7:0]  probe_v;
  logic [7:0]  gap;
  logic [7:0]  lvl;
  logic [7:0]  clamped;
  logic [8:0]  bot_try;
  logic [8:0]  top1_try;

  vcm_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .prod (mul_prod)
  );

  vcm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quo  (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_floor       <= FLOOR_RESET;
      level_ceiling     <= CEILING_RESET;
      slider_full_scale <= FULL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLOOR:   level_floor       <= cfg_data;
        REG_CEILING: level_ceiling     <= cfg_data;
        REG_FULL:    slider_full_scale <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign neg     = (level_ceiling < level_floor);
  assign mag     = neg ? (level_floor - level_ceiling) : (level_ceiling - level_floor);
  assign clamped = (value_in > slider_full_scale) ? slider_full_scale : value_in;

  // search midpoint, bot < top1 holds whenever it is used
  assign mid_sum = {1'b0, bot} + {1'b0, top1} - 10'd1;
  assign mid     = mid_sum[8:1];
  assign probe_v = (mode == OP_INVERSE) ? mid : vol;
  assign gap     = slider_full_scale - probe_v;
  assign lvl     = neg ? (level_floor - div_quo) : (level_floor + div_quo);

  always_comb begin
    state_next  = state;
    mode_next   = mode;
    target_next = target;
    vol_next    = vol;
    bot_next    = bot;
    top1_next   = top1;
    den_next    = den;
    result_next = result;
    load_out    = 1'b0;
    mreq        = '0;
    dreq        = '0;
    bot_try     = bot;
    top1_try    = top1;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          mode_next   = opcode;
          target_next = value_in;
          vol_next    = clamped;
          bot_next    = 9'd0;
          top1_next   = {1'b0, slider_full_scale} + 9'd1;
          if (slider_full_scale == 8'd0) begin
            result_next = (opcode == OP_INVERSE) ? 8'd0 : level_floor;
            state_next  = ST_FINISH;
          end else begin
            mreq.start = 1'b1;
            mreq.a     = {8'd0, slider_full_scale};
            mreq.b     = slider_full_scale;
            state_next = ST_DEN;
          end
        end
      end

      ST_DEN: begin
        if (mul_done) begin
          den_next   = mul_prod[15:0];
          state_next = ST_PROBE;
        end
      end

      ST_PROBE: begin
        vol_next   = probe_v;
        mreq.start = 1'b1;
        mreq.a     = {8'd0, gap};
        mreq.b     = gap;
        state_next = ST_GAP;
      end

      ST_GAP: begin
        if (mul_done) begin
          mreq.start = 1'b1;
          mreq.a     = den - mul_prod[15:0];
          mreq.b     = mag;
          state_next = ST_SPAN;
        end
      end

      ST_SPAN: begin
        if (mul_done) begin
          dreq.start = 1'b1;
          dreq.num   = mul_prod;
          dreq.den   = den;
          state_next = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          if (mode == OP_FORWARD) begin
            result_next = lvl;
            state_next  = ST_FINISH;
          end else if (target == lvl) begin
            result_next = vol;
            state_next  = ST_FINISH;
          end else begin
            if (target < lvl) begin
              top1_try = {1'b0, vol};
            end else begin
              bot_try = {1'b0, vol} + 9'd1;
            end
            bot_next  = bot_try;
            top1_next = top1_try;
            // search range empty: last probe is the answer
            if (bot_try < top1_try) begin
              state_next = ST_PROBE;
            end else begin
              result_next = vol;
              state_next  = ST_FINISH;
            end
          end
        end
      end

      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mode   <= mode_next;
    target <= target_next;
    vol    <= vol_next;
    bot    <= bot_next;
    top1   <= top1_next;
    den    <= den_next;
    result <= result_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value_out <= result;
    end
  end

  assign req_stall = (state != ST_IDLE);

endmodule

@@ rtl/vcm_mul.sv @@
// bit-serial shift-add multiplier, 16 x 8 bits, one multiplier bit per cycle
// depends on vcm_pkg
module vcm_mul import vcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mul_req_t    req,
  output logic        done,
  output logic [23:0] prod
);

  logic [23:0] acc;
  logic [23:0] mcand;
  logic [7:0]  mplier;
  logic [2:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else if (req.start) begin
      busy   <= 1'b1;
      done   <= 1'b0;
      cnt    <= 3'd0;
      acc    <= 24'd0;
      mcand  <= {8'd0, req.a};
      mplier <= req.b;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[22:0], 1'b0};
      mplier <= {1'b0, mplier[7:1]};
      cnt    <= cnt + 3'd1;
      done   <= (cnt == 3'd7);
      busy   <= (cnt != 3'd7);
    end else begin
      done <= 1'b0;
    end
  end

  assign prod = acc;

endmodule

@@ rtl/vcm_div.sv @@
// restoring divider, 24 by 16 bits with an 8-bit quotient, one bit per cycle
// depends on vcm_pkg; the caller guarantees the quotient fits 8 bits
module vcm_div import vcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  div_req_t   req,
  output logic       done,
  output logic [7:0] quo
);

  logic [23:0] rem;
  logic [22:0] dsh;
  logic [2:0]  cnt;
  logic        busy;
  logic        fits;

  assign fits = (rem >= {1'b0, dsh});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 3'd0;
      rem  <= req.num;
      dsh  <= {req.den, 7'd0};
      quo  <= 8'd0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - {1'b0, dsh};
      end
      quo  <= {quo[6:0], fits};
      dsh  <= {1'b0, dsh[22:1]};
      cnt  <= cnt + 3'd1;
      done <= (cnt == 3'd7);
      busy <= (cnt != 3'd7);
    end else begin
      done <= 1'b0;
    end
  end

endmodule

@@ tb/tb_volume_curve_map_and_inverse_unit.sv @@
`timescale 1ns / 1ps
// self-checking testbench for volume_curve_map_and_inverse_unit
// predicts each value_out from a shadow copy of the registers; needs vcm_pkg and the rtl
module tb_volume_curve_map_and_inverse_unit;
  import vcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 300;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 180;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       opcode    = OP_FORWARD;
  logic [7:0] value_in  = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [7:0] value_out;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_FLOOR;
  logic [7:0] cfg_data  = '0;

  // shadow registers
  logic [7:0] cfg_floor   = FLOOR_RESET;
  logic [7:0] cfg_ceiling = CEILING_RESET;
  logic [7:0] cfg_full    = FULL_RESET;

  logic [7:0] value_out_due[$];
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;

  volume_curve_map_and_inverse_unit u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .opcode(opcode), .value_in(value_in),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .value_out(value_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // level along the curve for slider v under the shadow registers
  function automatic int level_at(int v);
    int f, lo, span, mag, den, num, q, r;
    f = cfg_full;
    lo = cfg_floor;
    span = int'(cfg_ceiling) - lo;
    if (f <= 0) return lo;
    if (v < 0) v = 0;
    if (v > f) v = f;
    den = f * f;
    num = den - (f - v) * (f - v);
    mag = (span < 0) ? -span : span;
    q = (num * mag) / den;
    r = lo + ((span < 0) ? -q : q);
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r;
  endfunction

  function automatic logic [7:0] predict_level(logic [7:0] slider);
    int r;
    r = level_at(int'(slider));
    return r[7:0];
  endfunction

  // binary search; on a miss the last probe stands
  function automatic logic [7:0] predict_slider(logic [7:0] level);
    int f, top, bot, mid, lvl, target;
    logic hit;
    f = cfg_full;
    target = level;
    top = f;
    bot = 0;
    mid = 0;
    hit = 1'b0;
    while (bot <= top && !hit) begin
      mid = (top + bot) / 2;
      lvl = level_at(mid);
      if (target == lvl) hit = 1'b1;
      else if (target < lvl) top = mid - 1;
      else bot = mid + 1;
    end
    if (mid < 0) mid = 0;
    else if (mid > f) mid = f;
    return mid[7:0];
  endfunction

  // leaves valid high so a following item goes out without a gap
  task automatic send_item(logic op, logic [7:0] val);
    logic [7:0] due;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode    <= op;
    value_in  <= val;
    do @(posedge clk); while (req_stall);
    due = (op == OP_FORWARD) ? predict_level(val) : predict_slider(val);
    value_out_due.push_back(due);
  endtask

  task automatic wait_idle(int settle);
    req_valid <= 1'b0;
    while (value_out_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] lo, logic [7:0] hi, logic [7:0] full);
    wait_idle(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FLOOR;
    cfg_data  <= lo;
    cfg_floor  = lo;
    @(posedge clk);
    cfg_index <= REG_CEILING;
    cfg_data  <= hi;
    cfg_ceiling = hi;
    @(posedge clk);
    cfg_index <= REG_FULL;
    cfg_data  <= full;
    cfg_full   = full;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_reset_curve();
    send_item(OP_FORWARD, 8'd0);
    send_item(OP_FORWARD, 8'd100);
    send_item(OP_FORWARD, 8'd50);
    // slider above full scale saturates
    send_item(OP_FORWARD, 8'd255);
    send_item(OP_INVERSE, 8'd128);
    send_item(OP_INVERSE, 8'd255);
    // level below floor has no match
    send_item(OP_INVERSE, 8'd0);
    send_item(OP_INVERSE, 8'd200);
  endtask

  task automatic test_falling_curve();
    set_config(8'd200, 8'd10, 8'd100);
    send_item(OP_FORWARD, 8'd30);
    send_item(OP_INVERSE, 8'd10);
    send_item(OP_INVERSE, 8'd250);
  endtask

  task automatic test_scale_extremes();
    set_config(8'd0, 8'd255, 8'd255);
    send_item(OP_FORWARD, 8'd255);
    send_item(OP_FORWARD, 8'd1);
    send_item(OP_INVERSE, 8'd254);
    send_item(OP_INVERSE, 8'd255);
    set_config(8'd255, 8'd0, 8'd1);
    send_item(OP_FORWARD, 8'd0);
    send_item(OP_FORWARD, 8'd1);
    send_item(OP_INVERSE, 8'd128);
  endtask

  task automatic test_flat_curve();
    set_config(8'd77, 8'd77, 8'd7);
    send_item(OP_FORWARD, 8'd3);
    send_item(OP_INVERSE, 8'd77);
    send_item(OP_INVERSE, 8'd76);
  endtask

  task automatic test_zero_full_scale();
    set_config(8'd90, 8'd200, 8'd0);
    send_item(OP_FORWARD, 8'd0);
    send_item(OP_FORWARD, 8'd255);
    send_item(OP_INVERSE, 8'd90);
    send_item(OP_INVERSE, 8'd0);
  endtask

  function automatic logic [7:0] pick_reg(int low_bound);
    case ($urandom_range(3))
      0: return low_bound[7:0];
      1: return 8'd255;
      default: return 8'($urandom_range(255, low_bound));
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [7:0] lo, hi, full, val;
    logic       op;
    for (int p = 0; p < PHASES; p++) begin
      lo = pick_reg(0);
      hi = pick_reg(0);
      full = ($urandom_range(2) == 0) ? 8'($urandom_range(16, 1)) : pick_reg(1);
      set_config(lo, hi, full);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = $urandom_range(1) ? OP_INVERSE : OP_FORWARD;
        if (op == OP_FORWARD) begin
          val = ($urandom_range(3) != 0) ? 8'($urandom_range(cfg_full, 0))
                                          : 8'($urandom_range(255));
        end else begin
          // reachable levels exercise the exact-match exit
          val = $urandom_range(1) ? predict_level(8'($urandom_range(cfg_full, 0)))
                                  : 8'($urandom_range(255));
        end
        send_item(op, val);
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    logic [7:0] due;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (value_out_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: value_out=%0d", value_out);
      end else begin
        due = value_out_due.pop_front();
        if (value_out !== due) begin
          mismatches++;
          if (mismatches <= 10)
            $display("value_out mismatch: expected %0d, got %0d", due, value_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_curve();
    test_falling_curve();
    test_scale_extremes();
    test_flat_curve();
    test_zero_full_scale();
    test_random_traffic();
    wait_idle(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
